@@ design/tdq_pkg.sv @@
// Shared constants and types for the tagged drop-oldest match queue.
`default_nettype none

package tdq_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_TAG_BITS    = 32;
  localparam int unsigned DEF_HANDLE_BITS = 32;

  // APB register port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // cache_limit register
  localparam int unsigned         LIMIT_W     = 5;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 5'd16;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_LIMIT = 1'b0;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } tdq_state_e;

endpackage : tdq_pkg

`default_nettype wire

@@ design/tdq_store.sv @@
// Tag and handle entry memory: one write port, one registered read port.
`default_nettype none

module tdq_store #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 32,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           wr_en_i,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr_i,
  input  wire logic [TAG_BITS-1:0]            wr_tag_i,
  input  wire logic [HANDLE_BITS-1:0]         wr_handle_i,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr_i,
  output logic      [TAG_BITS-1:0]            rd_tag_o,
  output logic      [HANDLE_BITS-1:0]         rd_handle_o
);

  logic [TAG_BITS-1:0]    tag_mem    [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] handle_mem [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_addr_i]    <= wr_tag_i;
      handle_mem[wr_addr_i] <= wr_handle_i;
    end
  end

  // read before write on the same edge; the controller never relies on it
  always_ff @(posedge clk_i) begin
    rd_tag_o    <= tag_mem[rd_addr_i];
    rd_handle_o <= handle_mem[rd_addr_i];
  end

endmodule : tdq_store

`default_nettype wire

@@ design/tagged_drop_oldest_match_queue.sv @@
// Top level of the tagged drop-oldest queue with search by tag.
//
//  channel   | signals                                   | direction | flow control
//  ----------+-------------------------------------------+-----------+----------------------
//  request   | start_i, req_type_i, frame_tag_i,         | in        | transfer when start_i
//            | image_handle_i                            |           | high and busy_o low
//  result    | done_o, found_o, found_handle_o           | out       | one-cycle strobe,
//            |                                           |           | no back-pressure
//  config    | psel, penable, pwrite, paddr,             | in / out  | APB, pready tied high
//            | pwdata, prdata, pready                    |           |
//
// A push never raises busy_o and no result follows.
// A pop gives its result in the cycle after the last tag compared; it
// keeps busy_o high while it walks the entry memory from the oldest entry
// through its single read port, one entry per cycle, until a match or the
// newest entry. A pop on an empty queue answers in the next cycle without
// scanning.
// Reset clears head, count, limit and control; entry contents are left as
// they are and only live entries are ever compared. The result side cannot
// stall, so a new request may be taken in the cycle that the result shows.
`default_nettype none

module tagged_drop_oldest_match_queue #(
  parameter int unsigned QUEUE_DEPTH = tdq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned TAG_BITS    = tdq_pkg::DEF_TAG_BITS,
  parameter int unsigned HANDLE_BITS = tdq_pkg::DEF_HANDLE_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic                            req_type_i,
  input  wire logic [TAG_BITS-1:0]             frame_tag_i,
  input  wire logic [HANDLE_BITS-1:0]          image_handle_i,
  // result
  output logic                                 done_o,
  output logic                                 found_o,
  output logic      [HANDLE_BITS-1:0]          found_handle_o,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tdq_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [tdq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [tdq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  import tdq_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);      // slot index
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);  // count / offset
  localparam int unsigned SW = IW + 1;                   // head + offset
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;  // limit compare

  // slot of an offset from the head; the sum stays below twice the depth
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  tdq_state_e             state_q, state_d;
  logic [IW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          off_q, off_d;      // offset of the tag now compared
  logic [TAG_BITS-1:0]    key_q, key_d;      // tag searched by the pop
  logic [LIMIT_W-1:0]     limit_q;
  logic                   done_q, done_d;
  logic                   found_q, found_d;
  logic [HANDLE_BITS-1:0] fhandle_q, fhandle_d;

  // memory ports
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [IW-1:0]          rd_addr;
  logic [CW-1:0]          rd_off;
  logic [TAG_BITS-1:0]    rd_tag;
  logic [HANDLE_BITS-1:0] rd_handle;

  logic                   accept;
  logic                   cfg_wr;
  logic [LW-1:0]          eff_limit;
  logic [CW-1:0]          next_off;
  logic [IW-1:0]          push_head;
  logic [CW-1:0]          push_count;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr && paddr[2] == CFG_IDX_LIMIT) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_IDX_LIMIT) begin
      prdata = APB_DATA_W'(limit_q);
    end
  end

  // zero acts as one, anything above the depth as the depth
  always_comb begin
    eff_limit = LW'(limit_q);
    if (limit_q == '0) begin
      eff_limit = LW'(1);
    end else if (LW'(limit_q) > LW'(QUEUE_DEPTH)) begin
      eff_limit = LW'(QUEUE_DEPTH);
    end
  end

  // ---------------------------------------------------------------------
  // Entry memory
  // ---------------------------------------------------------------------
  tdq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_tag_i    (frame_tag_i),
    .wr_handle_i (image_handle_i),
    .rd_addr_i   (rd_addr),
    .rd_tag_o    (rd_tag),
    .rd_handle_o (rd_handle)
  );

  // Idle: read the oldest entry so its tag is ready when a pop is taken.
  // Scan: fetch the entry after the one being compared. Writes happen only
  // while idle, so read and write never overlap on a live entry.
  assign next_off = off_q + CW'(1);
  assign rd_off   = (state_q == ST_SCAN) ? next_off : '0;
  assign rd_addr  = slot_of(head_q, rd_off);

  // push: drop the oldest first once the limit is reached
  always_comb begin
    push_head  = head_q;
    push_count = count_q;
    if (LW'(count_q) >= eff_limit) begin
      push_head  = slot_of(head_q, CW'(1));
      push_count = count_q - CW'(1);
    end
  end
  assign wr_addr = slot_of(push_head, push_count);

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  assign busy_o = (state_q == ST_SCAN);
  assign accept = start_i & ~busy_o;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    off_d     = off_q;
    key_d     = key_q;
    done_d    = 1'b0;
    found_d   = found_q;
    fhandle_d = fhandle_q;
    wr_en     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_PUSH) begin
            wr_en   = 1'b1;
            head_d  = push_head;
            count_d = push_count + CW'(1);
          end else begin
            key_d = frame_tag_i;
            off_d = '0;
            if (count_q == '0) begin
              done_d    = 1'b1;
              found_d   = 1'b0;
              fhandle_d = '0;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (rd_tag == key_q) begin
          // hit: discard it and everything older
          done_d    = 1'b1;
          found_d   = 1'b1;
          fhandle_d = rd_handle;
          head_d    = slot_of(head_q, next_off);
          count_d   = count_q - next_off;
          state_d   = ST_IDLE;
        end else if (next_off == count_q) begin
          done_d    = 1'b1;
          found_d   = 1'b0;
          fhandle_d = '0;
          state_d   = ST_IDLE;
        end else begin
          off_d = next_off;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      off_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      off_q   <= off_d;
      done_q  <= done_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    found_q   <= found_d;
    fhandle_q <= fhandle_d;
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign found_handle_o = fhandle_q;

endmodule : tagged_drop_oldest_match_queue

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the tagged drop-oldest match queue.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tdq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int unsigned TAG_BITS    = DEF_TAG_BITS;
  localparam int unsigned HANDLE_BITS = DEF_HANDLE_BITS;
  // cache_limit is register 0, so it sits at byte address 0
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = '0;
  // quiet time after the last result: longest pop plus a margin
  localparam int unsigned SETTLE_CYCLES = QUEUE_DEPTH + 4;

  typedef struct packed {
    logic                   req;
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;
  } request_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                   found;
    logic [HANDLE_BITS-1:0] handle;
  } lookup_t;

  // clock, reset and stimulus, all known from time zero
  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start_i        = 1'b0;
  logic                   req_type_i     = REQ_PUSH;
  logic [TAG_BITS-1:0]    frame_tag_i    = '0;
  logic [HANDLE_BITS-1:0] image_handle_i = '0;
  logic                   psel           = 1'b0;
  logic                   penable        = 1'b0;
  logic                   pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr          = '0;
  logic [APB_DATA_W-1:0]  pwdata         = '0;

  logic                   busy_o;
  logic                   done_o;
  logic                   found_o;
  logic [HANDLE_BITS-1:0] found_handle_o;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // predictor state: live entries oldest first, and the limit register
  entry_t                 held_entries[$];
  logic [LIMIT_W-1:0]     limit_reg = LIMIT_RESET;

  request_t               request_fifo[$];   // items waiting for the driver
  lookup_t                awaited[$];        // lookups predicted, not yet seen
  request_t               on_bus;            // item currently offered
  int unsigned            sent_count  = 0;
  int unsigned            error_count = 0;

  tagged_drop_oldest_match_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .frame_tag_i    (frame_tag_i),
    .image_handle_i (image_handle_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .found_handle_o (found_handle_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_error(input string what);
    error_count++;
    $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Expected behaviour of one accepted transfer.
  task automatic predict_transfer(input request_t r);
    int unsigned lim;
    lookup_t     res;
    entry_t      ent;
    int          hit;
    lim = 32'(limit_reg);
    if (lim == 0) lim = 1;                       // zero limit acts as one
    if (lim > QUEUE_DEPTH) lim = QUEUE_DEPTH;    // saturate at the depth
    if (r.req == REQ_PUSH) begin
      // a push drops at most one oldest entry, even if the limit was lowered
      if (held_entries.size() >= lim) held_entries.delete(0);
      if (held_entries.size() >= QUEUE_DEPTH) held_entries.delete(0);
      ent.tag      = r.tag;
      ent.handle   = r.handle;
      held_entries = {held_entries, ent};
    end else begin
      hit = -1;
      foreach (held_entries[i]) begin
        if (hit < 0 && held_entries[i].tag == r.tag) hit = i;
      end
      if (hit < 0) begin
        res = '{found: 1'b0, handle: '0};        // miss leaves the queue alone
      end else begin
        // oldest match wins; it and everything older go
        res = '{found: 1'b1, handle: held_entries[hit].handle};
        repeat (hit + 1) held_entries.delete(0);
      end
      awaited = {awaited, res};
    end
  endtask

  // ---------------------------------------------------------------------
  // Request driver: offers queued items with random gaps. A transfer is
  // taken at an edge with start high and busy low; the item is held until
  // then. Between items the payload ports carry junk.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_requests
    request_t nxt;
    bit       calm;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_transfer(on_bus);
        sent_count++;
      end
      if (!start_i || !busy_o) begin
        // a run of items with no gaps in the middle of the random part
        calm = (sent_count >= 180 && sent_count < 280);
        if (request_fifo.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
          nxt            = request_fifo[0];
          request_fifo.delete(0);
          on_bus         = nxt;
          start_i        <= 1'b1;
          req_type_i     <= nxt.req;
          frame_tag_i    <= nxt.tag;
          image_handle_i <= nxt.handle;
        end else begin
          start_i        <= 1'b0;
          req_type_i     <= 1'($urandom_range(0, 1));
          frame_tag_i    <= $urandom;
          image_handle_i <= $urandom;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: each strobe is checked against the oldest lookup.
  // The result side has no back-pressure, so every strobe is a transfer.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_results
    lookup_t want;
    if (rst_ni && done_o) begin
      if (awaited.size() == 0) begin
        flag_error("result strobe with no lookup outstanding");
      end else begin
        want = awaited[0];
        awaited.delete(0);
        if (found_o !== want.found)
          flag_error($sformatf("found: got %b, want %b", found_o, want.found));
        if (found_handle_o !== want.handle)
          flag_error($sformatf("found_handle: got %h, want %h",
                               found_handle_o, want.handle));
      end
    end
  end

  // One APB transfer: setup cycle, then access cycle. The register takes
  // the write at the access edge, which is where the predictor follows.
  task automatic apb_transfer(input bit is_write, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    if (is_write) limit_reg = wdata[LIMIT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_limit_readback();
    logic [APB_DATA_W-1:0] rd;
    apb_transfer(1'b0, $urandom, rd);
    if (rd !== APB_DATA_W'(limit_reg))
      flag_error($sformatf("cache_limit readback: got %h, want %h", rd, limit_reg));
  endtask

  // Write the limit with junk in the unused upper bits, then read it back.
  task automatic set_limit(input logic [LIMIT_W-1:0] lim);
    logic [APB_DATA_W-1:0] wd;
    logic [APB_DATA_W-1:0] rd;
    wd = $urandom;
    wd[LIMIT_W-1:0] = lim;
    apb_transfer(1'b1, wd, rd);
    check_limit_readback();
  endtask

  task automatic queue_item(input logic req, input logic [TAG_BITS-1:0] tag,
                            input logic [HANDLE_BITS-1:0] handle);
    request_t item;
    item.req     = req;
    item.tag     = tag;
    item.handle  = handle;
    request_fifo = {request_fifo, item};
  endtask

  // Wait for the driver to empty and every lookup to return, then let the
  // block settle: a trailing push gives no strobe to wait for. Sampled on
  // the falling edge, once the driver's updates have landed.
  task automatic drain();
    do @(negedge clk_i);
    while (request_fifo.size() > 0 || start_i || busy_o || awaited.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Sequence: reset, directed checks, then random phases at a spread of
  // limits. The queue contents carry over between phases, so lowering the
  // limit below the live count is exercised too.
  // ---------------------------------------------------------------------
  initial begin : run_sequence
    logic [LIMIT_W-1:0]  phase_limits[8];
    logic [TAG_BITS-1:0] tag_pool[8];
    logic [TAG_BITS-1:0] tag;
    int                  pick;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_limit_readback();   // reset value of the limit
    set_limit(5'd16);

    // directed, limit 16
    queue_item(REQ_POP,  32'h0000_0000, 32'hFFFF_FFFF);  // pop on empty queue
    queue_item(REQ_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(REQ_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(REQ_PUSH, 32'h0000_0005, 32'h0000_0011);
    queue_item(REQ_PUSH, 32'h0000_0005, 32'h0000_0022);  // duplicate tag
    queue_item(REQ_POP,  32'h0000_0005, 32'h1234_5678);  // oldest dup, drops older
    queue_item(REQ_POP,  32'h0000_0005, 32'h0000_0000);  // second dup
    queue_item(REQ_POP,  32'hFFFF_FFFF, 32'h0000_0000);  // miss, already dropped
    queue_item(REQ_PUSH, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    queue_item(REQ_PUSH, 32'h0000_0001, 32'h0000_0002);
    queue_item(REQ_POP,  32'h1234_5678, 32'h0000_0000);  // miss on a two-entry queue
    queue_item(REQ_POP,  32'h0000_0001, 32'h0000_0000);  // hit on the newer entry
    drain();

    // limit of one: second push evicts the first
    set_limit(5'd1);
    queue_item(REQ_PUSH, 32'h0000_0003, 32'h0000_0003);
    queue_item(REQ_PUSH, 32'h0000_0004, 32'h0000_0004);
    queue_item(REQ_POP,  32'h0000_0003, 32'h0000_0000);
    queue_item(REQ_POP,  32'h0000_0004, 32'h0000_0000);
    drain();

    // limit of zero behaves as one
    set_limit(5'd0);
    queue_item(REQ_PUSH, 32'h0000_0007, 32'hDEAD_0001);
    queue_item(REQ_PUSH, 32'h0000_0008, 32'hDEAD_0002);
    queue_item(REQ_POP,  32'h0000_0007, 32'h0000_0000);
    queue_item(REQ_POP,  32'h0000_0008, 32'h0000_0000);
    drain();

    // random phases; 31 and 17 saturate, 16 then 4 lowers below the count
    phase_limits = '{5'd31, 5'd16, 5'd4, 5'd1, 5'd0, 5'd17, 5'd2, 5'd0};
    phase_limits[7] = LIMIT_W'($urandom_range(0, 31));
    foreach (phase_limits[ph]) begin
      set_limit(phase_limits[ph]);
      foreach (tag_pool[k]) tag_pool[k] = $urandom;
      repeat (50) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      tag = tag_pool[$urandom_range(0, 7)];
        else if (pick < 85) tag = '1;
        else if (pick < 90) tag = '0;
        else                tag = $urandom;
        // push-heavy so the queue fills and pops find their tags
        queue_item(($urandom_range(0, 99) < 60) ? REQ_PUSH : REQ_POP, tag, $urandom);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule : testbench

`default_nettype wire
